>>> src/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants for the graph reachability block
// Field widths, item kind codes and the control/status bundles that pass
// between the sequencer and the frontier unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

  localparam int VERTEX_W = 6;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic init;   // load start vertex, clear search state
    logic merge;  // fold a fetched adjacency row into the search state
  } fr_ctrl_t;

  typedef struct packed {
    logic empty;  // no vertex left to expand
    logic found;  // goal has been reached
  } fr_stat_t;

endpackage

`default_nettype wire

>>> src/gbr_adj_ram.sv
// ----------------------------------------------------------------------------
// gbr_adj_ram: adjacency matrix storage
// One row per vertex, one write and one registered read per cycle. A row
// valid bit per entry makes every row read as empty after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_adj_ram #(
  parameter int ROWS = 64,
  parameter int IDXW = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [IDXW-1:0] rd_addr,
  output logic      [ROWS-1:0] rd_row,
  input  wire logic            wr_en,
  input  wire logic [IDXW-1:0] wr_addr,
  input  wire logic [ROWS-1:0] wr_row
);

  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [ROWS-1:0] rd_data;
  logic            rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

>>> src/gbr_frontier.sv
// ----------------------------------------------------------------------------
// gbr_frontier: search state and row merge unit
// Holds the visited and pending vertex sets. Each merge retires one pending
// vertex and adds its unvisited neighbors to the pending set.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_frontier #(
  parameter int ROWS = 64,
  parameter int IDXW = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gbr_pkg::fr_ctrl_t ctrl,
  input  wire logic [IDXW-1:0]  start_idx,
  input  wire logic [IDXW-1:0]  goal_idx,
  input  wire logic [IDXW-1:0]  merge_idx,
  input  wire logic [ROWS-1:0]  row,
  input  wire logic [IDXW-1:0]  scan_idx,
  output logic                  pend_hit,
  output gbr_pkg::fr_stat_t     stat
);

  logic [ROWS-1:0] visited;
  logic [ROWS-1:0] pending;
  logic [ROWS-1:0] visited_next;
  logic [ROWS-1:0] pending_next;
  logic [ROWS-1:0] start_bit;
  logic [ROWS-1:0] merge_bit;

  assign start_bit = ROWS'(1) << start_idx;
  assign merge_bit = ROWS'(1) << merge_idx;

  always_comb begin
    visited_next = visited;
    pending_next = pending;
    priority if (ctrl.init) begin
      visited_next = start_bit;
      pending_next = start_bit;
    end else if (ctrl.merge) begin
      visited_next = visited | row;
      pending_next = (pending & ~merge_bit) | (row & ~visited);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      pending <= '0;
    end else begin
      visited <= visited_next;
      pending <= pending_next;
    end
  end

  assign pend_hit   = pending[scan_idx];
  assign stat.empty = ~|pending;
  assign stat.found = visited[goal_idx];

endmodule

`default_nettype wire

>>> src/graph_bfs_reachability.sv
// ----------------------------------------------------------------------------
// graph_bfs_reachability: undirected graph reachability engine
// Adjacency bit matrix with edge insert and breadth-first reachability query.
// ----------------------------------------------------------------------------
// An edge add does a read-modify-write of row a, then of row b, in the
// adjacency RAM. A query whose start equals its goal, or that names a vertex
// outside the graph, goes straight to the reply state without a search. Any
// other query sweeps the vertex indices, issuing one adjacency row read per
// cycle and merging each fetched row of a pending vertex into the visited
// set; the search needs at most one sweep per BFS level plus one. The block
// takes one item at a time; a finished result sits in the output register
// while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_reachability #(
  parameter int VERTICES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         kind,
  input  wire logic [gbr_pkg::VERTEX_W-1:0] vertex_a,
  input  wire logic [gbr_pkg::VERTEX_W-1:0] vertex_b,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              connected
);

  // vertex fields reach only the first 64 indices
  localparam int ROWS = (VERTICES < (1 << gbr_pkg::VERTEX_W)) ? VERTICES
                                                              : (1 << gbr_pkg::VERTEX_W);
  localparam int IDXW = $clog2(ROWS);
  localparam logic [gbr_pkg::VERTEX_W:0] ROWS_LIM = (gbr_pkg::VERTEX_W + 1)'(ROWS);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ROWS - 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD_RD_A = 7'b0000010,
    S_ADD_WR_A = 7'b0000100,
    S_ADD_RD_B = 7'b0001000,
    S_ADD_WR_B = 7'b0010000,
    S_SEARCH   = 7'b0100000,
    S_REPLY    = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [IDXW-1:0]   idx_a, idx_b;
  logic [IDXW-1:0]   idx_a_next, idx_b_next;
  logic [IDXW-1:0]   scan, scan_next;
  logic              rd_take, rd_take_next;
  logic [IDXW-1:0]   rd_idx;
  logic              result, result_next;
  logic              out_valid_next, connected_next;

  logic              in_xfer;
  logic              a_ok, b_ok;
  logic              finish;
  logic [IDXW-1:0]   rd_addr;
  logic [ROWS-1:0]   rd_row;
  logic              wr_en;
  logic [IDXW-1:0]   wr_addr;
  logic [ROWS-1:0]   wr_row;
  logic              pend_hit;
  gbr_pkg::fr_ctrl_t fr_ctrl;
  gbr_pkg::fr_stat_t fr_stat;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign a_ok     = {1'b0, vertex_a} < ROWS_LIM;
  assign b_ok     = {1'b0, vertex_b} < ROWS_LIM;
  assign finish   = fr_stat.found || fr_stat.empty;

  gbr_adj_ram #(.ROWS(ROWS), .IDXW(IDXW)) u_adj (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row)
  );

  gbr_frontier #(.ROWS(ROWS), .IDXW(IDXW)) u_frontier (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fr_ctrl),
    .start_idx (vertex_a[IDXW-1:0]),
    .goal_idx  (idx_b),
    .merge_idx (rd_idx),
    .row       (rd_row),
    .scan_idx  (scan),
    .pend_hit  (pend_hit),
    .stat      (fr_stat)
  );

  always_comb begin
    state_next     = state;
    idx_a_next     = idx_a;
    idx_b_next     = idx_b;
    scan_next      = scan;
    rd_take_next   = 1'b0;
    result_next    = result;
    out_valid_next = out_valid && !out_ready;
    connected_next = connected;
    rd_addr        = scan;
    wr_en          = 1'b0;
    wr_addr        = idx_a;
    wr_row         = rd_row | (ROWS'(1) << idx_b);
    fr_ctrl.init   = 1'b0;
    fr_ctrl.merge  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          idx_a_next = vertex_a[IDXW-1:0];
          idx_b_next = vertex_b[IDXW-1:0];
          scan_next  = '0;
          if (kind == gbr_pkg::KIND_ADD) begin
            if (a_ok && b_ok) begin
              state_next = S_ADD_RD_A;
            end
          end else if (vertex_a == vertex_b) begin
            result_next = 1'b1;
            state_next  = S_REPLY;
          end else if (!(a_ok && b_ok)) begin
            result_next = 1'b0;
            state_next  = S_REPLY;
          end else begin
            fr_ctrl.init = 1'b1;
            state_next   = S_SEARCH;
          end
        end
      end
      S_ADD_RD_A: begin
        rd_addr    = idx_a;
        state_next = S_ADD_WR_A;
      end
      S_ADD_WR_A: begin
        wr_en      = 1'b1;
        state_next = S_ADD_RD_B;
      end
      S_ADD_RD_B: begin
        rd_addr    = idx_b;
        state_next = S_ADD_WR_B;
      end
      S_ADD_WR_B: begin
        wr_en      = 1'b1;
        wr_addr    = idx_b;
        wr_row     = rd_row | (ROWS'(1) << idx_a);
        state_next = S_IDLE;
      end
      S_SEARCH: begin
        fr_ctrl.merge = rd_take;
        if (finish) begin
          result_next = fr_stat.found;
          state_next  = S_REPLY;
        end else begin
          rd_take_next = pend_hit;
          scan_next    = (scan == LAST_IDX) ? '0 : scan + IDXW'(1);
        end
      end
      S_REPLY: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          connected_next = result;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_take   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_take   <= rd_take_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_a     <= idx_a_next;
    idx_b     <= idx_b_next;
    scan      <= scan_next;
    rd_idx    <= scan;
    result    <= result_next;
    connected <= connected_next;
  end

  // row fetch stage is only live during a search
  a_take_in_search: assert property (@(posedge clk) disable iff (rst)
    rd_take |-> state == S_SEARCH)
    else $error("row fetch in flight outside search");

  // a fetched pending row always keeps the frontier nonempty until merged
  a_no_fetch_when_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && fr_stat.empty) |-> !rd_take)
    else $error("frontier empty with pending row fetch");

  a_add_sequence: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD_WR_A |=> state == S_ADD_RD_B)
    else $error("edge add skipped second row update");

  a_result_from_reply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_REPLY)
    else $error("result raised outside reply state");

endmodule

`default_nettype wire
